// File: sv/afws_pkg.sv
// Shared types and constants for the aging FIFO window sum block.
// No dependencies; afws_if, afws_dp, afws_ctrl and the top file import this package.
package afws_pkg;

	// Default number of places in the entry store.
	localparam int DEPTH_DEF = 128;

	// Field widths.
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 48;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W = 2;

	// Reset value of the places register.
	localparam logic [COUNT_W-1:0] PLACES_RESET = 8'd100;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_AMOUNT = 2'd0,
		REG_INCREMENT      = 2'd1,
		REG_PLACES         = 2'd2
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // request taken, latch the value
		logic load;      // stored entry is on the read port, update the store
		logic sum;       // fold the step's terms into the running total
		logic div_go;    // start the mean division
		logic out_load;  // move the finished result into the output register
	} afws_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} afws_stat_t;

endpackage

// File: sv/afws_if.sv
// Valid/ready channel interfaces for the aging FIFO window sum block.
// Depends on afws_pkg for the field widths.

// Input channel: one Q16.16 value per request.
interface afws_in_if;
	import afws_pkg::*;

	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] value_in;

	modport source (output valid, output value_in, input ready);
	modport sink (input valid, input value_in, output ready);
endinterface

// Output channel: one result per request.
interface afws_out_if;
	import afws_pkg::*;

	logic valid;
	logic ready;
	logic signed [TOTAL_W-1:0] total;
	logic signed [VALUE_W-1:0] mean;
	logic [COUNT_W-1:0] held_count;
	logic signed [VALUE_W-1:0] dropped;

	modport source (output valid, output total, output mean, output held_count,
		output dropped, input ready);
	modport sink (input valid, input total, input mean, input held_count,
		input dropped, output ready);
endinterface

// File: sv/afws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module afws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/afws_div.sv
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// No dependencies; used by afws_dp for the mean.
module afws_div #(
	parameter int NW = 48,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_shift;
	logic [DW:0]   rem_diff;
	logic          bit_set;

	// Shift in the next dividend bit and try the subtraction.
	always_comb begin
		rem_shift = {rem_q, quo_q[NW-1]};
		rem_diff = rem_shift - {1'b0, den_q};
		bit_set = (rem_shift >= {1'b0, den_q});
	end

	// Control: step counter, busy flag and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: the quotient replaces the dividend bit by bit.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], bit_set};
			rem_q <= bit_set ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/afws_dp.sv
// Datapath of the aging FIFO window sum: configuration registers, entry store,
// running total, mean divider and output register. Depends on afws_pkg,
// afws_ram and afws_div.
module afws_dp #(
	parameter int DEPTH = afws_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [afws_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [afws_pkg::VALUE_W-1:0]     wr_data,
	input  logic [afws_pkg::VALUE_W-1:0]     value_in,
	input  logic                             out_ready,
	input  afws_pkg::afws_cmd_t              cmd,
	output afws_pkg::afws_stat_t             stat,
	output logic                             out_valid,
	output logic [afws_pkg::TOTAL_W-1:0]     total,
	output logic [afws_pkg::VALUE_W-1:0]     mean,
	output logic [afws_pkg::COUNT_W-1:0]     held_count,
	output logic [afws_pkg::VALUE_W-1:0]     dropped
);
	import afws_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
	localparam int PW = COUNT_W + 1 + VALUE_W;

	// Configuration registers.
	logic [VALUE_W-1:0] initial_amount_q;
	logic [VALUE_W-1:0] increment_q;
	logic [COUNT_W-1:0] places_q;

	// Window state. Entries are stored minus the increment sum applied so far,
	// so one add of the increment sum ages every held entry at once.
	logic [AW-1:0]      oldest_q;
	logic [COUNT_W-1:0] fill_q;
	logic [VALUE_W-1:0] age_q;
	logic [TOTAL_W-1:0] total_q;
	logic               first_q;

	// Per-request working registers.
	logic [VALUE_W-1:0] entry_q;
	logic               drop_q;
	logic [VALUE_W-1:0] taken_q;
	logic [VALUE_W:0]   partial_q;
	logic [PW-1:0]      prod_q;
	logic               neg_q;

	// Output register.
	logic               out_valid_q;
	logic [TOTAL_W-1:0] total_out_q;
	logic [VALUE_W-1:0] mean_out_q;
	logic [COUNT_W-1:0] count_out_q;
	logic [VALUE_W-1:0] dropped_out_q;

	logic [COUNT_W-1:0] cap;
	logic [COUNT_W-1:0] fill_new;
	logic [AW-1:0]      oldest_next;
	logic [SW-1:0]      wsum;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] rd_data;
	logic [VALUE_W-1:0] taken;
	logic [TOTAL_W-1:0] magnitude;
	logic [TOTAL_W-1:0] quotient;
	logic [VALUE_W-1:0] mean_sat;
	logic               div_busy;
	logic               div_done;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_amount_q <= '0;
			increment_q <= '0;
			places_q <= PLACES_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_INITIAL_AMOUNT: initial_amount_q <= wr_data;
				REG_INCREMENT:      increment_q <= wr_data;
				REG_PLACES:         places_q <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capacity in use: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (places_q == '0) begin
			cap = COUNT_W'(1);
		end else if (32'(places_q) > 32'(DEPTH)) begin
			cap = COUNT_W'(DEPTH);
		end else begin
			cap = places_q;
		end
	end

	// Store addressing. The write lands at oldest plus fill, which stays below
	// twice the depth, so one compare and subtract wraps it.
	always_comb begin
		fill_new = drop_q ? fill_q : fill_q + 1'b1;
		if (SW'(oldest_q) == SW'(DEPTH - 1)) begin
			oldest_next = '0;
		end else begin
			oldest_next = oldest_q + 1'b1;
		end
		wsum = SW'(oldest_q) + SW'(fill_q);
		if (wsum >= SW'(DEPTH)) begin
			wsum = wsum - SW'(DEPTH);
		end
		waddr = wsum[AW-1:0];
		taken = drop_q ? rd_data + age_q : '0;
	end

	afws_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(waddr),
		.wdata(entry_q - age_q),
		.raddr(oldest_q),
		.rdata(rd_data)
	);

	// Window control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q <= '0;
			age_q <= '0;
			total_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd.accept) begin
				first_q <= 1'b0;
			end
			if (cmd.load) begin
				if (drop_q) begin
					oldest_q <= oldest_next;
				end
				fill_q <= fill_new;
				age_q <= age_q + increment_q;
			end
			if (cmd.sum) begin
				total_q <= total_q + {{(TOTAL_W - PW){prod_q[PW-1]}}, prod_q}
					+ {{(TOTAL_W - VALUE_W - 1){partial_q[VALUE_W]}}, partial_q};
			end
		end
	end

	// Per-request terms: new entry, dropped entry and fill times increment.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			entry_q <= value_in + (first_q ? initial_amount_q : '0);
			drop_q <= (fill_q >= cap);
		end
		if (cmd.load) begin
			taken_q <= taken;
			partial_q <= {entry_q[VALUE_W-1], entry_q} - {taken[VALUE_W-1], taken};
			prod_q <= PW'($signed({1'b0, fill_new}) * $signed(increment_q));
		end
		if (cmd.div_go) begin
			neg_q <= total_q[TOTAL_W-1];
		end
	end

	// Mean: divide the magnitude of the total, then restore sign and saturate.
	assign magnitude = total_q[TOTAL_W-1] ? ~total_q + 1'b1 : total_q;

	afws_div #(
		.NW(TOTAL_W),
		.DW(COUNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_go),
		.dividend(magnitude),
		.divisor (fill_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quotient)
	);

	always_comb begin
		if (!neg_q) begin
			if (quotient > TOTAL_W'(32'h7FFF_FFFF)) begin
				mean_sat = 32'h7FFF_FFFF;
			end else begin
				mean_sat = quotient[VALUE_W-1:0];
			end
		end else begin
			if (quotient > TOTAL_W'(32'h8000_0000)) begin
				mean_sat = 32'h8000_0000;
			end else begin
				mean_sat = ~quotient[VALUE_W-1:0] + 1'b1;
			end
		end
	end

	// Output register; the next request can be worked on while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			total_out_q <= total_q;
			mean_out_q <= mean_sat;
			count_out_q <= fill_q;
			dropped_out_q <= taken_q;
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign total = total_out_q;
	assign mean = mean_out_q;
	assign held_count = count_out_q;
	assign dropped = dropped_out_q;

	// The fill count never passes the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(DEPTH))
		else $error("fill count exceeds store depth");

	// A step that drops the oldest entry leaves the fill count unchanged.
	a_drop_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && drop_q |=> $stable(fill_q))
		else $error("fill count changed on a dropping step");

	// After a store update at least one entry is held.
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> fill_q != '0)
		else $error("no entry held after a store update");

	// A result never overwrites one that has not been taken.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule

// File: sv/afws_ctrl.sv
// Controller of the aging FIFO window sum: sequences one request through the
// store update, total update, mean division and output load. Depends on afws_pkg.
module afws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  afws_pkg::afws_stat_t stat,
	output logic                 in_ready,
	output afws_pkg::afws_cmd_t  cmd
);
	import afws_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_LOAD     = 6'b000010,
		ST_SUM      = 6'b000100,
		ST_DIV_GO   = 6'b001000,
		ST_DIV_WAIT = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The divider is running in the cycle after it is started.
	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_GO |=> stat.div_busy)
		else $error("divider did not start");

endmodule

// File: sv/aging_fifo_window_sum.sv
// Aging FIFO window sum: a sliding window of Q16.16 values whose entries
// grow by a common increment each step, with running total and mean.
// Usage:
//   samples carries one signed Q16.16 value per request (valid/ready).
//   results returns one item per request: total, mean, held_count, dropped.
//   wr_en/wr_index/wr_data write initial_amount (0), increment (1) and
//   places (2); write them only while no request is in flight.
// Sequence:
//   After acceptance a request passes through the store write, the total
//   update, the divider start, the bit-serial 48-bit by 8-bit mean division,
//   a step to see the division finish and the load of the output register.
//   The next request is taken in the cycle after the output load, so a new
//   request is not taken before the last one is in the output register.
//   The result waits in an output register; the next request is accepted
//   and worked on meanwhile, and holds before its output load while the
//   receiver stalls.
// Reset: arst_n clears the window, the total and the registers (places to
//   100); the first value after reset gets initial_amount added. The entry
//   store needs no clearing.
module aging_fifo_window_sum #(
	parameter int DEPTH = afws_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [afws_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [afws_pkg::VALUE_W-1:0]   wr_data,
	afws_in_if.sink                        samples,
	afws_out_if.source                     results
);
	import afws_pkg::*;

	afws_cmd_t  cmd;
	afws_stat_t stat;

	afws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.stat    (stat),
		.in_ready(samples.ready),
		.cmd     (cmd)
	);

	afws_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.value_in  (samples.value_in),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (results.valid),
		.total     (results.total),
		.mean      (results.mean),
		.held_count(results.held_count),
		.dropped   (results.dropped)
	);

endmodule
